// File: rtl/onewb_pkg.sv
// ----------------------------------------------------------------------------
// onewb_pkg
// Shared types and constants for the 1-Wire bus master.
// ----------------------------------------------------------------------------
package onewb_pkg;

    // Configuration register indexes
    localparam int unsigned CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] CFG_RESET_LOW  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_PRES_SAMP  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_PRES_TAIL  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_SLOT       = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_START      = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_READ_SAMP  = 3'd5;
    localparam int unsigned CfgDataW = 10;

    // Register reset values
    localparam logic [9:0] RESET_LOW_DEF = 10'd500;
    localparam logic [9:0] PRES_SAMP_DEF = 10'd100;
    localparam logic [9:0] PRES_TAIL_DEF = 10'd400;
    localparam logic [7:0] SLOT_DEF      = 8'd50;
    localparam logic [3:0] START_DEF     = 4'd2;
    localparam logic [3:0] READ_SAMP_DEF = 4'd5;

    // Depth of the queue between front and engine
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // Request kinds carried in the mode field
    typedef enum logic [1:0] {
        REQ_NONE  = 2'd0,
        REQ_RESET = 2'd1,
        REQ_WRITE = 2'd2,
        REQ_READ  = 2'd3
    } req_kind_t;

    // Sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_TAIL = 4'd3,
        PH_WRITE    = 4'd4,
        PH_READ     = 4'd5
    } phase_t;

    // One tick as held in the queue
    typedef struct packed {
        req_kind_t  kind;
        logic [7:0] write_value;
        logic       bus_level;
    } tick_item_t;

    // One result tick
    typedef struct packed {
        logic [7:0] read_value;
        logic       present;
        logic       done_res;
        logic       busy_res;
        logic       pull_low;
    } tick_result_t;

    // Timing configuration
    typedef struct packed {
        logic [9:0] reset_low_time;
        logic [9:0] presence_sample_time;
        logic [9:0] presence_tail_time;
        logic [7:0] slot_time;
        logic [3:0] start_pulse_time;
        logic [3:0] read_sample_time;
    } timing_cfg_t;

    // Queue head toward the engine
    typedef struct packed {
        logic       valid;
        tick_item_t item;
    } queue_head_t;

endpackage

// File: rtl/onewb_front.sv
// ----------------------------------------------------------------------------
// onewb_front
// Input side: takes tick transfers, decodes the request kind and queues
// them for the engine in a small FIFO.
// ----------------------------------------------------------------------------
module onewb_front
    import onewb_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  in_mode,
    input  logic [7:0]  in_write_value,
    input  logic        in_bus_level,
    output queue_head_t head,
    input  logic        pop
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    tick_item_t           store [DEPTH];
    logic [PtrW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]      count_reg, count_next;
    logic                 push;
    logic                 do_pop;
    tick_item_t           new_item;

    // Classify the incoming transfer
    always_comb
    begin
        new_item.kind        = req_kind_t'(in_mode);
        new_item.write_value = in_write_value;
        new_item.bus_level   = in_bus_level;
    end

    assign in_ready   = (count_reg != FullCnt);
    assign push       = in_valid && in_ready;
    assign head.valid = (count_reg != '0);
    assign head.item  = store[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// File: rtl/onewb_engine.sv
// ----------------------------------------------------------------------------
// onewb_engine
// Bus sequencer: advances one tick per queued item and registers the
// per-tick result for the output channel.
// ----------------------------------------------------------------------------
module onewb_engine
    import onewb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  timing_cfg_t  cfg,
    input  queue_head_t  head,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_ready,
    output tick_result_t out_data
);

    phase_t       phase_reg, phase_next;
    logic [9:0]   tick_reg, tick_next;
    logic [2:0]   bit_reg, bit_next;
    logic [7:0]   shift_reg, shift_next;
    logic         pres_reg, pres_next;
    logic [7:0]   hold_reg, hold_next;
    logic         out_valid_reg;
    tick_result_t out_data_reg;

    logic         step;
    logic         pull;
    logic         done;
    logic [10:0]  tick_inc;
    logic [9:0]   low_min;
    logic [9:0]   samp_min;
    logic [7:0]   slot_min;
    logic [7:0]   read_pos;
    logic         cur_bit;

    // Timing values with zero treated as one tick
    assign low_min  = (cfg.reset_low_time == '0) ? 10'd1 : cfg.reset_low_time;
    assign samp_min = (cfg.presence_sample_time == '0) ? 10'd1 : cfg.presence_sample_time;
    assign slot_min = (cfg.slot_time == '0) ? 8'd1 : cfg.slot_time;
    assign read_pos = ({4'd0, cfg.read_sample_time} < slot_min)
                      ? {4'd0, cfg.read_sample_time} : slot_min - 8'd1;

    // Advance when a tick is queued and the output register is free
    assign step = head.valid && (!out_valid_reg || out_ready);
    assign pop  = step;

    // One tick of the bus sequencer
    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        pres_next  = pres_reg;
        hold_next  = hold_reg;
        pull       = 1'b0;
        done       = 1'b0;
        cur_bit    = 1'b0;

        // Start of a request
        if (phase_reg == PH_IDLE)
        begin
            tick_next = '0;
            bit_next  = '0;
            case (head.item.kind)
                REQ_RESET: phase_next = PH_RST_LOW;
                REQ_WRITE:
                begin
                    phase_next = PH_WRITE;
                    shift_next = head.item.write_value;
                end
                REQ_READ:
                begin
                    phase_next = PH_READ;
                    shift_next = '0;
                end
                default: ;
            endcase
        end

        tick_inc = {1'b0, tick_next} + 11'd1;

        case (phase_next)
            PH_IDLE: ;
            PH_RST_LOW:
            begin
                pull      = 1'b1;
                tick_next = tick_inc[9:0];
                if (tick_inc >= {1'b0, low_min})
                begin
                    phase_next = PH_RST_WAIT;
                    tick_next  = '0;
                end
            end
            PH_RST_WAIT:
            begin
                tick_next = tick_inc[9:0];
                if (tick_inc >= {1'b0, samp_min})
                begin
                    pres_next = !head.item.bus_level;
                    tick_next = '0;
                    if (pres_next && (cfg.presence_tail_time != '0))
                    begin
                        phase_next = PH_RST_TAIL;
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                end
            end
            PH_RST_TAIL:
            begin
                tick_next = tick_inc[9:0];
                if (tick_inc >= {1'b0, cfg.presence_tail_time})
                begin
                    tick_next = '0;
                    done      = 1'b1;
                end
            end
            PH_WRITE, PH_READ:
            begin
                cur_bit = shift_next[bit_next];
                if (phase_next == PH_WRITE)
                begin
                    pull = (tick_next < {6'd0, cfg.start_pulse_time})
                        || ((tick_inc < {3'd0, slot_min}) && !cur_bit);
                end
                else
                begin
                    pull = (tick_next < {6'd0, cfg.start_pulse_time});
                    if (tick_next == {2'd0, read_pos})
                    begin
                        shift_next[bit_next] = cur_bit | head.item.bus_level;
                    end
                end
                tick_next = tick_inc[9:0];
                if (tick_inc >= {3'd0, slot_min})
                begin
                    tick_next = '0;
                    if (bit_next == 3'd7)
                    begin
                        if (phase_next == PH_READ)
                        begin
                            hold_next = shift_next;
                        end
                        bit_next = '0;
                        done     = 1'b1;
                    end
                    else
                    begin
                        bit_next = bit_next + 3'd1;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                tick_next  = '0;
            end
        endcase

        if (done)
        begin
            phase_next = PH_IDLE;
        end
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            pres_reg  <= 1'b0;
            hold_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            pres_reg  <= pres_next;
            hold_reg  <= hold_next;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg.pull_low   <= pull;
            out_data_reg.busy_res   <= (phase_next != PH_IDLE);
            out_data_reg.done_res   <= done;
            out_data_reg.present    <= pres_next;
            out_data_reg.read_value <= hold_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master
// 1-Wire bus master advanced by one tick transfer per microsecond.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one tick per transfer: tuser holds the request mode,
//   tdata the byte to write and the sampled bus level. While idle, a mode
//   of reset, write byte or read byte starts a request; otherwise mode is
//   ignored. m_axis returns exactly one result per tick: pull_low to drive
//   the open-drain line, busy, a one-tick done flag, the last presence
//   result and the last byte read.
//   Timing registers are written over cfg_we/cfg_index/cfg_wdata; the
//   user must write them only while no request is running, as the
//   block itself does not enforce it. Throughput: one tick per clock
//   cycle while m_axis does not stall. A tick is written into the input
//   queue, then stepped from the queue head into the output register.
//   When m_axis stalls, the output register holds its result and the
//   input queue (QUEUE_DEPTH ticks) fills before s_axis_tready drops.
//   Reset empties the queue, returns the sequencer to idle with cleared
//   presence and read byte, and loads the default timing values.
// ----------------------------------------------------------------------------
module one_wire_bus_master
    import onewb_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    // Tick input
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [15:0]         s_axis_tdata,   // [7:0] write_value, [8] bus_level
    input  logic [1:0]          s_axis_tuser,   // [1:0] mode
    // Tick result
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [15:0]         m_axis_tdata,   // [0] pull_low, [1] busy_res,
                                                // [2] done_res, [3] present,
                                                // [11:4] read_value
    // Timing register writes
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_wdata
);

    timing_cfg_t  cfg_reg;
    queue_head_t  head;
    logic         pop;
    tick_result_t res;

    // Timing register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_time       <= RESET_LOW_DEF;
            cfg_reg.presence_sample_time <= PRES_SAMP_DEF;
            cfg_reg.presence_tail_time   <= PRES_TAIL_DEF;
            cfg_reg.slot_time            <= SLOT_DEF;
            cfg_reg.start_pulse_time     <= START_DEF;
            cfg_reg.read_sample_time     <= READ_SAMP_DEF;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RESET_LOW: cfg_reg.reset_low_time       <= cfg_wdata;
                CFG_PRES_SAMP: cfg_reg.presence_sample_time <= cfg_wdata;
                CFG_PRES_TAIL: cfg_reg.presence_tail_time   <= cfg_wdata;
                CFG_SLOT:      cfg_reg.slot_time            <= cfg_wdata[7:0];
                CFG_START:     cfg_reg.start_pulse_time     <= cfg_wdata[3:0];
                CFG_READ_SAMP: cfg_reg.read_sample_time     <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // Input queue
    onewb_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .in_mode        (s_axis_tuser),
        .in_write_value (s_axis_tdata[7:0]),
        .in_bus_level   (s_axis_tdata[8]),
        .head           (head),
        .pop            (pop)
    );

    // Bus sequencer
    onewb_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (head),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res)
    );

    // Result packing
    assign m_axis_tdata = {4'd0, res.read_value, res.present,
                           res.done_res, res.busy_res, res.pull_low};

endmodule

// File: tb/one_wire_bus_master_test.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_test
// Self-checking regression for the 1-Wire bus master. Microsecond ticks are
// streamed in with random bus levels and the result of every tick is compared
// against a tick-accurate model of the sequencer. A short directed pass covers
// the default start pulse and read sample timing, zero and minimum timings,
// the longest start pulse and read sample, a late and an early read sample,
// a start pulse covering the whole slot and ignored register indexes.
// Randomized requests follow under small timing settings while both stream
// sides stall at varying rates.
// ----------------------------------------------------------------------------
module one_wire_bus_master_test;
    import onewb_pkg::*;

    // Register indexes the block does not implement
    localparam logic [CfgIdxW-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_SPARE_7 = 3'd7;

    // How the bus line behaves during one request
    typedef enum int {
        BUS_NOISE,
        BUS_LOW,
        BUS_HIGH
    } bus_drive_t;

    // ------------------------------------------------------------------
    // Tick model and result scoreboard
    // ------------------------------------------------------------------
    class tick_scoreboard;
        timing_cfg_t  timing;
        phase_t       seq_phase;
        int unsigned  tick_cnt;
        int unsigned  bit_idx;
        logic [7:0]   shreg;
        logic         presence;
        logic [7:0]   read_byte;
        tick_result_t expected_ticks[$];
        int           errors;

        function new();
            timing.reset_low_time       = RESET_LOW_DEF;
            timing.presence_sample_time = PRES_SAMP_DEF;
            timing.presence_tail_time   = PRES_TAIL_DEF;
            timing.slot_time            = SLOT_DEF;
            timing.start_pulse_time     = START_DEF;
            timing.read_sample_time     = READ_SAMP_DEF;
            seq_phase = PH_IDLE;
            tick_cnt  = 0;
            bit_idx   = 0;
            shreg     = '0;
            presence  = 1'b0;
            read_byte = '0;
            errors    = 0;
        endfunction

        // Zero timing values act as one tick
        function int unsigned floor_one(int unsigned v);
            return (v == 0) ? 1 : v;
        endfunction

        function bit busy();
            return seq_phase != PH_IDLE;
        endfunction

        function int pending();
            return expected_ticks.size();
        endfunction

        function void set_timing(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
            case (idx)
                CFG_RESET_LOW: timing.reset_low_time       = val[9:0];
                CFG_PRES_SAMP: timing.presence_sample_time = val[9:0];
                CFG_PRES_TAIL: timing.presence_tail_time   = val[9:0];
                CFG_SLOT:      timing.slot_time            = val[7:0];
                CFG_START:     timing.start_pulse_time     = val[3:0];
                CFG_READ_SAMP: timing.read_sample_time     = val[3:0];
                default: ;
            endcase
        endfunction

        // Advance the sequencer by one accepted tick and queue its result
        function void note_tick(req_kind_t mode, logic [7:0] wval, logic bus);
            tick_result_t r;
            logic         done;
            int unsigned  slot;
            int unsigned  samp;
            int unsigned  pos;
            r    = '0;
            done = 1'b0;

            // Requests are taken only while idle
            if (seq_phase == PH_IDLE) begin
                tick_cnt = 0;
                bit_idx  = 0;
                case (mode)
                    REQ_RESET: seq_phase = PH_RST_LOW;
                    REQ_WRITE:
                    begin
                        seq_phase = PH_WRITE;
                        shreg     = wval;
                    end
                    REQ_READ:
                    begin
                        seq_phase = PH_READ;
                        shreg     = '0;
                    end
                    default: ;
                endcase
            end

            case (seq_phase)
                PH_RST_LOW:
                begin
                    r.pull_low = 1'b1;
                    tick_cnt++;
                    if (tick_cnt >= floor_one(timing.reset_low_time)) begin
                        seq_phase = PH_RST_WAIT;
                        tick_cnt  = 0;
                    end
                end
                PH_RST_WAIT:
                begin
                    tick_cnt++;
                    if (tick_cnt >= floor_one(timing.presence_sample_time)) begin
                        presence = ~bus;
                        tick_cnt = 0;
                        if (presence && timing.presence_tail_time != 0)
                            seq_phase = PH_RST_TAIL;
                        else
                            done = 1'b1;
                    end
                end
                PH_RST_TAIL:
                begin
                    tick_cnt++;
                    if (tick_cnt >= timing.presence_tail_time) begin
                        tick_cnt = 0;
                        done     = 1'b1;
                    end
                end
                PH_WRITE, PH_READ:
                begin
                    slot = floor_one(timing.slot_time);
                    pos  = tick_cnt;
                    if (seq_phase == PH_WRITE) begin
                        // last slot tick is recovery unless the start pulse covers it
                        r.pull_low = (pos < timing.start_pulse_time) ||
                                     ((pos + 1 < slot) && !shreg[bit_idx]);
                    end else begin
                        samp = (timing.read_sample_time < slot) ?
                               timing.read_sample_time : slot - 1;
                        r.pull_low = (pos < timing.start_pulse_time);
                        if (pos == samp)
                            shreg[bit_idx] = shreg[bit_idx] | bus;
                    end
                    tick_cnt++;
                    if (tick_cnt >= slot) begin
                        tick_cnt = 0;
                        if (bit_idx >= 7) begin
                            if (seq_phase == PH_READ)
                                read_byte = shreg;
                            bit_idx = 0;
                            done    = 1'b1;
                        end else begin
                            bit_idx++;
                        end
                    end
                end
                default: ;
            endcase

            if (done)
                seq_phase = PH_IDLE;

            r.busy_res   = (seq_phase != PH_IDLE);
            r.done_res   = done;
            r.present    = presence;
            r.read_value = read_byte;
            expected_ticks.push_back(r);
        endfunction

        function void compare(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                errors++;
                $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                         $time, name, exp_v, act_v);
            end
        endfunction

        // Compare one result transfer against the oldest expectation
        function void check_result(logic [15:0] data);
            tick_result_t act;
            tick_result_t exp_r;
            act = tick_result_t'(data[11:0]);
            if (expected_ticks.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual 0x%0h",
                         $time, data);
                return;
            end
            exp_r = expected_ticks.pop_front();
            compare("pull_low",   exp_r.pull_low,   act.pull_low);
            compare("busy_res",   exp_r.busy_res,   act.busy_res);
            compare("done_res",   exp_r.done_res,   act.done_res);
            compare("present",    exp_r.present,    act.present);
            compare("read_value", exp_r.read_value, act.read_value);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------
    logic                clk;
    logic                rst_n         = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [15:0]         s_axis_tdata  = '0;
    logic [1:0]          s_axis_tuser  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [15:0]         m_axis_tdata;
    logic                cfg_we        = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index     = '0;
    logic [CfgDataW-1:0] cfg_wdata     = '0;

    tick_scoreboard board;
    int sender_idle_pct = 0;
    int recv_idle_pct   = 0;
    int hold_cycles     = 0;
    int n_resets        = 0;
    int n_present       = 0;
    int n_writes        = 0;
    int n_reads         = 0;
    int n_settings      = 0;

    one_wire_bus_master dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // Clock and reset
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Hard stop
    initial
    begin
        #40_000_000;
        $display("one_wire_bus_master regression: fail");
        $finish;
    end

    // Result side: check each transfer, then pick next tready
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    function automatic logic pick_bus(bus_drive_t drv);
        case (drv)
            BUS_LOW:  return 1'b0;
            BUS_HIGH: return 1'b1;
            default:  return 1'($urandom);
        endcase
    endfunction

    // One tick transfer, with a random gap in front
    task automatic send_tick(req_kind_t mode, logic [7:0] wval, logic bus);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {7'b0, bus, wval};
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_tick(mode, wval, bus);
    endtask

    // Start a request and keep ticking until the sequencer is idle again;
    // modes offered while busy are noise the block must ignore
    task automatic run_request(req_kind_t kind, logic [7:0] wval, bus_drive_t drv);
        send_tick(kind, wval, pick_bus(drv));
        while (board.busy())
            send_tick(req_kind_t'($urandom_range(0, 3)), 8'($urandom), pick_bus(drv));
        case (kind)
            REQ_RESET:
            begin
                n_resets++;
                if (board.presence)
                    n_present++;
            end
            REQ_WRITE: n_writes++;
            REQ_READ:  n_reads++;
            default: ;
        endcase
    endtask

    // Pause the sender until every result is back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        board.set_timing(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_timing(int unsigned rl, int unsigned ps, int unsigned pt,
                                int unsigned sl, int unsigned sp, int unsigned rs);
        drain();
        write_reg(CFG_RESET_LOW, CfgDataW'(rl));
        write_reg(CFG_PRES_SAMP, CfgDataW'(ps));
        write_reg(CFG_PRES_TAIL, CfgDataW'(pt));
        write_reg(CFG_SLOT,      CfgDataW'(sl));
        write_reg(CFG_START,     CfgDataW'(sp));
        write_reg(CFG_READ_SAMP, CfgDataW'(rs));
        n_settings++;
    endtask

    // Small random timing so that requests stay short
    task automatic random_timing();
        int unsigned sp;
        int unsigned rs;
        sp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
        rs = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 5);
        apply_timing($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 6),
                     $urandom_range(0, 4), sp, rs);
    endtask

    task automatic random_request();
        req_kind_t  kind;
        bus_drive_t drv;
        // idle ticks with no request now and then
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3))
                send_tick(REQ_NONE, 8'($urandom), 1'($urandom));
        kind = req_kind_t'($urandom_range(1, 3));
        case ($urandom_range(0, 3))
            2:       drv = BUS_LOW;
            3:       drv = BUS_HIGH;
            default: drv = BUS_NOISE;
        endcase
        run_request(kind, 8'($urandom), drv);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        board = new();
        @(posedge rst_n);
        @(posedge clk);

        sender_idle_pct = 6;
        recv_idle_pct   = 87;

        // Directed: idle ticks after reset, then a short slot with the
        // default start pulse and read sample
        repeat (3) send_tick(REQ_NONE, 8'hFF, 1'b1);
        drain();
        write_reg(CFG_SLOT, CfgDataW'(6));
        n_settings++;
        run_request(REQ_WRITE, 8'h6C, BUS_NOISE);
        run_request(REQ_READ,  8'h00, BUS_NOISE);

        // All-zero timing: one-tick phases, presence tail skipped
        apply_timing(0, 0, 0, 0, 0, 0);
        run_request(REQ_RESET, 8'h00, BUS_LOW);
        run_request(REQ_WRITE, 8'hA5, BUS_NOISE);
        run_request(REQ_READ,  8'h00, BUS_NOISE);

        // Minimum legal timing
        apply_timing(1, 1, 1, 1, 1, 1);
        run_request(REQ_RESET, 8'h00, BUS_LOW);
        run_request(REQ_WRITE, 8'h5A, BUS_NOISE);
        run_request(REQ_READ,  8'h00, BUS_NOISE);

        // Read sample past the end of the slot
        apply_timing(4, 4, 3, 4, 1, 15);
        run_request(REQ_READ, 8'h00, BUS_NOISE);

        // Start pulse covering the slot, read sampled inside the start pulse
        apply_timing(3, 3, 2, 5, 8, 2);
        run_request(REQ_READ,  8'h00, BUS_NOISE);
        run_request(REQ_WRITE, 8'h5A, BUS_NOISE);

        // Longest start pulse and read sample
        apply_timing(2, 3, 2, 16, 15, 15);
        run_request(REQ_READ,  8'h00, BUS_NOISE);
        run_request(REQ_RESET, 8'h00, BUS_LOW);

        // Writes to unused indexes must leave timing alone
        apply_timing(5, 6, 7, 4, 3, 2);
        write_reg(CFG_SPARE_6, 10'h3FF);
        write_reg(CFG_SPARE_7, 10'h000);
        run_request(REQ_WRITE, 8'h96, BUS_NOISE);
        run_request(REQ_RESET, 8'h00, BUS_LOW);

        // Random requests under three stall profiles
        for (int seg = 0; seg < 3; seg++)
        begin
            case (seg)
                0:
                begin
                    sender_idle_pct = 6;
                    recv_idle_pct   = 87;
                end
                1:
                begin
                    sender_idle_pct = 87;
                    recv_idle_pct   = 6;
                end
                default:
                begin
                    sender_idle_pct = 0;
                    recv_idle_pct   = 0;
                end
            endcase
            for (int p = 0; p < 3; p++)
            begin
                random_timing();
                // long result stall while ticks keep coming: input queue fills
                if (seg == 2 && p == 0) begin
                    hold_cycles = 300;
                    run_request(REQ_WRITE, 8'($urandom), BUS_NOISE);
                end
                repeat (4) random_request();
            end
        end

        drain();
        repeat (10) @(posedge clk);

        $display("covered %0d resets (%0d answered), %0d writes, %0d reads",
                 n_resets, n_present, n_writes, n_reads);
        $display("over %0d timing settings, with zero, minimum and long-pulse timing",
                 n_settings);
        if (board.errors == 0 && board.pending() == 0)
            $display("one_wire_bus_master regression: pass");
        else
            $display("one_wire_bus_master regression: fail");
        $finish;
    end

endmodule
